[rtl/core/http_chunked_body_decoder_top_assert.svh]
// Assertion macros used by the chunked body decoder parser.
// Used by modules that include this header by its bare file name.
`ifndef HTTP_CHUNKED_BODY_DECODER_TOP_ASSERT_SVH
`define HTTP_CHUNKED_BODY_DECODER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HCBD_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("hcbd assertion failed: same-cycle check");

// The consequent must hold in the cycle after the antecedent.
`define HCBD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("hcbd assertion failed: next-cycle check");

`endif

[rtl/core/hcbd_pkg.sv]
// Package for the HTTP chunked body decoder: word types, parser phases,
// result codes, character constants and the hex digit decoder.
package hcbd_pkg;

    localparam int SIZE_BITS_DEF = 32;
    localparam logic [7:0] MAX_LINE_RESET = 8'd64;

    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;
    localparam logic [7:0] CHAR_SP = 8'h20;

    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_END     = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;

    typedef enum logic [3:0] {
        PH_LEAD,
        PH_DIGITS,
        PH_DATA,
        PH_DATA_CR,
        PH_DATA_LF,
        PH_END_CR,
        PH_END_LF,
        PH_DONE,
        PH_FAILED
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       message_start;
    } in_word_t;

    typedef struct packed {
        logic [1:0] result_kind;
        logic [7:0] payload_byte;
    } out_word_t;

    // Returns {is_hex, value}.
    function automatic logic [4:0] hex_decode(input logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b inside {[8'h30:8'h39]}) begin
            r = {1'b1, 4'(b - 8'h30)};
        end else if (b inside {[8'h61:8'h66]}) begin
            r = {1'b1, 4'(b - 8'h57)};
        end else if (b inside {[8'h41:8'h46]}) begin
            r = {1'b1, 4'(b - 8'h37)};
        end
        return r;
    endfunction

endpackage

[rtl/core/hcbd_in_reg.sv]
// Input register stage of the chunked body decoder.
// Depends on hcbd_pkg for the input word type.
module hcbd_in_reg (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  hcbd_pkg::in_word_t s_word,
    input  logic              advance,
    output logic              hold_valid,
    output hcbd_pkg::in_word_t hold_word
);

    logic               valid_reg;
    logic               valid_next;
    hcbd_pkg::in_word_t word_reg;

    assign s_ready    = !valid_reg || advance;
    assign hold_valid = valid_reg;
    assign hold_word  = word_reg;

    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            word_reg <= s_word;
        end
    end

endmodule

[rtl/core/hcbd_parser.sv]
// Chunk framing state machine: size line parsing, payload count and CRLF checks.
// Depends on hcbd_pkg and the assertion macro header.
`include "http_chunked_body_decoder_top_assert.svh"

module hcbd_parser #(
    parameter int SIZE_BITS = hcbd_pkg::SIZE_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                go,
    input  hcbd_pkg::in_word_t  in_word,
    input  logic                cfg_wr_en,
    input  logic [7:0]          cfg_wr_data,
    output logic                res_valid,
    output hcbd_pkg::out_word_t res_word
);

    hcbd_pkg::phase_t       phase_reg, phase_next;
    logic [SIZE_BITS-1:0]   rem_reg, rem_next;
    logic [7:0]             len_reg, len_next;
    logic                   dd_reg, dd_next;
    logic                   crs_reg, crs_next;
    logic [7:0]             max_len_reg;

    hcbd_pkg::phase_t       ph_eff;
    logic [SIZE_BITS-1:0]   rem_eff;
    logic [7:0]             len_eff;
    logic                   dd_eff;
    logic                   crs_eff;
    logic [7:0]             b;

    logic [8:0]             len_p1;
    logic                   cr_ok;
    logic [7:0]             len_a;
    logic                   dd_a;
    logic [8:0]             len_a_p1;
    logic                   ch_ok;
    logic [4:0]             hex;
    logic                   top_clear;
    logic [SIZE_BITS-1:0]   rem_dec;

    logic                   sl_fail;
    hcbd_pkg::phase_t       sl_phase;
    logic [SIZE_BITS-1:0]   sl_rem;
    logic [7:0]             sl_len;
    logic                   sl_dd;
    logic                   sl_crs;

    assign b       = in_word.data_byte;
    assign ph_eff  = in_word.message_start ? hcbd_pkg::PH_LEAD : phase_reg;
    assign rem_eff = in_word.message_start ? '0 : rem_reg;
    assign len_eff = in_word.message_start ? 8'd0 : len_reg;
    assign dd_eff  = in_word.message_start ? 1'b0 : dd_reg;
    assign crs_eff = in_word.message_start ? 1'b0 : crs_reg;

    assign len_p1    = {1'b0, len_eff} + 9'd1;
    assign cr_ok     = len_p1 <= {1'b0, max_len_reg};
    assign len_a     = crs_eff ? len_p1[7:0] : len_eff;
    assign dd_a      = crs_eff | dd_eff;
    assign len_a_p1  = {1'b0, len_a} + 9'd1;
    assign ch_ok     = len_a_p1 <= {1'b0, max_len_reg};
    assign hex       = hcbd_pkg::hex_decode(b);
    assign top_clear = rem_eff[SIZE_BITS-1 -: 4] == 4'd0;
    assign rem_dec   = rem_eff - {{(SIZE_BITS-1){1'b0}}, 1'b1};

    // A pending CR that is not followed by LF counts as an ordinary character first.
    always_comb begin
        sl_fail  = 1'b0;
        sl_phase = ph_eff;
        sl_rem   = rem_eff;
        sl_len   = len_eff;
        sl_dd    = dd_eff;
        sl_crs   = crs_eff;
        if (crs_eff && b == hcbd_pkg::CHAR_LF) begin
            sl_crs   = 1'b0;
            sl_len   = 8'd0;
            sl_dd    = 1'b0;
            sl_phase = (rem_eff == '0) ? hcbd_pkg::PH_END_CR : hcbd_pkg::PH_DATA;
        end else if (crs_eff && !cr_ok) begin
            sl_fail = 1'b1;
        end else if (b == hcbd_pkg::CHAR_CR) begin
            sl_crs = 1'b1;
            sl_len = len_a;
            sl_dd  = dd_a;
        end else if (!ch_ok) begin
            sl_fail = 1'b1;
        end else begin
            sl_crs = 1'b0;
            sl_len = len_a_p1[7:0];
            sl_dd  = dd_a;
            if (!dd_a && !(ph_eff == hcbd_pkg::PH_LEAD && b == hcbd_pkg::CHAR_SP)) begin
                if (!hex[4]) begin
                    sl_dd = 1'b1;
                end else if (!top_clear) begin
                    sl_fail = 1'b1;
                end else begin
                    sl_rem   = {rem_eff[SIZE_BITS-5:0], hex[3:0]};
                    sl_phase = hcbd_pkg::PH_DIGITS;
                end
            end
        end
    end

    always_comb begin
        phase_next = ph_eff;
        rem_next   = rem_eff;
        len_next   = len_eff;
        dd_next    = dd_eff;
        crs_next   = crs_eff;
        case (ph_eff)
            hcbd_pkg::PH_LEAD, hcbd_pkg::PH_DIGITS: begin
                phase_next = sl_fail ? hcbd_pkg::PH_FAILED : sl_phase;
                rem_next   = sl_rem;
                len_next   = sl_len;
                dd_next    = sl_dd;
                crs_next   = sl_crs;
            end
            hcbd_pkg::PH_DATA: begin
                rem_next = rem_dec;
                if (rem_dec == '0) begin
                    phase_next = hcbd_pkg::PH_DATA_CR;
                end
            end
            hcbd_pkg::PH_DATA_CR: begin
                phase_next = (b == hcbd_pkg::CHAR_CR) ? hcbd_pkg::PH_DATA_LF
                                                      : hcbd_pkg::PH_FAILED;
            end
            hcbd_pkg::PH_DATA_LF: begin
                phase_next = (b == hcbd_pkg::CHAR_LF) ? hcbd_pkg::PH_LEAD
                                                      : hcbd_pkg::PH_FAILED;
            end
            hcbd_pkg::PH_END_CR: begin
                phase_next = (b == hcbd_pkg::CHAR_CR) ? hcbd_pkg::PH_END_LF
                                                      : hcbd_pkg::PH_FAILED;
            end
            hcbd_pkg::PH_END_LF: begin
                phase_next = (b == hcbd_pkg::CHAR_LF) ? hcbd_pkg::PH_DONE
                                                      : hcbd_pkg::PH_FAILED;
            end
            default: begin
                phase_next = ph_eff;
            end
        endcase
    end

    always_comb begin
        res_valid             = 1'b0;
        res_word.result_kind  = hcbd_pkg::KIND_ERROR;
        res_word.payload_byte = 8'd0;
        case (ph_eff)
            hcbd_pkg::PH_LEAD, hcbd_pkg::PH_DIGITS: begin
                res_valid = sl_fail;
            end
            hcbd_pkg::PH_DATA: begin
                res_valid             = 1'b1;
                res_word.result_kind  = hcbd_pkg::KIND_PAYLOAD;
                res_word.payload_byte = b;
            end
            hcbd_pkg::PH_DATA_CR, hcbd_pkg::PH_END_CR: begin
                res_valid = b != hcbd_pkg::CHAR_CR;
            end
            hcbd_pkg::PH_DATA_LF: begin
                res_valid = b != hcbd_pkg::CHAR_LF;
            end
            hcbd_pkg::PH_END_LF: begin
                res_valid = 1'b1;
                if (b == hcbd_pkg::CHAR_LF) begin
                    res_word.result_kind = hcbd_pkg::KIND_END;
                end
            end
            default: begin
                res_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= hcbd_pkg::PH_LEAD;
            rem_reg   <= '0;
            len_reg   <= 8'd0;
            dd_reg    <= 1'b0;
            crs_reg   <= 1'b0;
        end else if (go) begin
            phase_reg <= phase_next;
            rem_reg   <= rem_next;
            len_reg   <= len_next;
            dd_reg    <= dd_next;
            crs_reg   <= crs_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_len_reg <= hcbd_pkg::MAX_LINE_RESET;
        end else if (cfg_wr_en) begin
            max_len_reg <= cfg_wr_data;
        end
    end

    `HCBD_ASSERT_SAME(a_quiet_after_end, aclk, aresetn, go && !in_word.message_start && (phase_reg == hcbd_pkg::PH_DONE || phase_reg == hcbd_pkg::PH_FAILED), !res_valid)
    `HCBD_ASSERT_SAME(a_data_count_nonzero, aclk, aresetn, phase_reg == hcbd_pkg::PH_DATA, rem_reg != '0)
    `HCBD_ASSERT_NEXT(a_error_latches, aclk, aresetn, go && res_valid && res_word.result_kind == hcbd_pkg::KIND_ERROR, phase_reg == hcbd_pkg::PH_FAILED)

endmodule

[rtl/core/hcbd_out_reg.sv]
// Output register stage of the chunked body decoder.
// Depends on hcbd_pkg for the result word type.
module hcbd_out_reg (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                go,
    input  logic                res_valid,
    input  hcbd_pkg::out_word_t res_word,
    output logic                out_free,
    output logic                m_valid,
    input  logic                m_ready,
    output hcbd_pkg::out_word_t m_word
);

    logic                valid_reg;
    logic                valid_next;
    hcbd_pkg::out_word_t word_reg;

    assign out_free = !valid_reg || m_ready;
    assign m_valid  = valid_reg;
    assign m_word   = word_reg;

    always_comb begin
        valid_next = valid_reg;
        if (go) begin
            valid_next = res_valid;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (go && res_valid) begin
            word_reg <= res_word;
        end
    end

endmodule

[rtl/core/http_chunked_body_decoder_top.sv]
// Top level of the HTTP chunked body decoder.
// Depends on hcbd_pkg, hcbd_in_reg, hcbd_parser and hcbd_out_reg.
//
//  Port group   Direction  Word type   Meaning
//  s_*          in         in_word_t   raw body bytes with message start flag
//  m_*          out        out_word_t  payload bytes, end of body, framing error
//  cfg_wr_*     in         8 bits      longest accepted chunk size line
//
// One byte is taken per cycle unless m_* stalls; any result it gives shows on m_*.
// The parser state updates from the input register to the result register.
// A stall on m_ready holds both stages and backs up into s_ready.
// Reset is synchronous and sets the size line limit to 64.
module http_chunked_body_decoder_top #(
    parameter int SIZE_BITS = hcbd_pkg::SIZE_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  hcbd_pkg::in_word_t  s_word,
    output logic                m_valid,
    input  logic                m_ready,
    output hcbd_pkg::out_word_t m_word,
    input  logic                cfg_wr_en,
    input  logic [7:0]          cfg_wr_data
);

    logic                hold_valid;
    hcbd_pkg::in_word_t  hold_word;
    logic                out_free;
    logic                go;
    logic                res_valid;
    hcbd_pkg::out_word_t res_word;

    assign go = hold_valid && out_free;

    hcbd_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_word     (s_word),
        .advance    (go),
        .hold_valid (hold_valid),
        .hold_word  (hold_word)
    );

    hcbd_parser #(
        .SIZE_BITS (SIZE_BITS)
    ) u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .go          (go),
        .in_word     (hold_word),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .res_valid   (res_valid),
        .res_word    (res_word)
    );

    hcbd_out_reg u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .go        (go),
        .res_valid (res_valid),
        .res_word  (res_word),
        .out_free  (out_free),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_word    (m_word)
    );

endmodule

[tb/sv/hcbd_decode_checker.sv]
// Checker for the HTTP chunked body decoder: mirrors the parser on every accepted input word
// and compares each output word with the oldest predicted word.
// Depends on hcbd_pkg for the word types, parser phases, result codes and character constants.
module hcbd_decode_checker #(
    parameter int SIZE_BITS = hcbd_pkg::SIZE_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  hcbd_pkg::in_word_t  s_word,
    input  logic                m_valid,
    input  logic                m_ready,
    input  hcbd_pkg::out_word_t m_word,
    input  logic                cfg_wr_en,
    input  logic [7:0]          cfg_wr_data,
    output int unsigned         mismatch_count,
    output int unsigned         backlog,
    output int unsigned         payload_count,
    output int unsigned         end_count,
    output int unsigned         error_count
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [7:0]           line_limit;
    hcbd_pkg::phase_t     phase;
    logic [SIZE_BITS-1:0] chunk_left;
    int unsigned          line_len;
    bit                   digits_over;
    bit                   cr_held;
    hcbd_pkg::out_word_t  predicted_words[$];
    hcbd_pkg::out_word_t  want;
    hcbd_pkg::out_word_t  produced;
    int unsigned          n_bad;
    int unsigned          n_pay;
    int unsigned          n_end;
    int unsigned          n_err;

    initial begin
        n_bad = 0;
        n_pay = 0;
        n_end = 0;
        n_err = 0;
    end

    function automatic void clear_parser();
        phase = hcbd_pkg::PH_LEAD;
        chunk_left = '0;
        line_len = 0;
        digits_over = 1'b0;
        cr_held = 1'b0;
    endfunction

    function automatic bit take_size_char(input logic [7:0] c);
        int unsigned v;
        if (line_len + 1 > line_limit) return 1'b0;
        line_len++;
        if (digits_over) return 1'b1;
        if (phase == hcbd_pkg::PH_LEAD && c == hcbd_pkg::CHAR_SP) return 1'b1;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = c - 8'h30;
        end else if (c >= 8'h61 && c <= 8'h66) begin
            v = c - 8'h61 + 10;
        end else if (c >= 8'h41 && c <= 8'h46) begin
            v = c - 8'h41 + 10;
        end else begin
            v = 16;
        end
        if (v > 15) begin
            digits_over = 1'b1;
            return 1'b1;
        end
        if (chunk_left[SIZE_BITS-1 -: 4] != 0) return 1'b0;
        chunk_left = {chunk_left[SIZE_BITS-5:0], 4'(v)};
        phase = hcbd_pkg::PH_DIGITS;
        return 1'b1;
    endfunction

    function automatic bit reject(output hcbd_pkg::out_word_t r);
        phase = hcbd_pkg::PH_FAILED;
        r.result_kind = hcbd_pkg::KIND_ERROR;
        r.payload_byte = '0;
        return 1'b1;
    endfunction

    function automatic bit decode_byte(input hcbd_pkg::in_word_t w,
                                       output hcbd_pkg::out_word_t r);
        logic [7:0] b;
        b = w.data_byte;
        r = '0;
        if (w.message_start) clear_parser();
        case (phase)
            hcbd_pkg::PH_LEAD, hcbd_pkg::PH_DIGITS: begin
                if (cr_held && b == hcbd_pkg::CHAR_LF) begin
                    cr_held = 1'b0;
                    line_len = 0;
                    digits_over = 1'b0;
                    phase = (chunk_left == 0) ? hcbd_pkg::PH_END_CR : hcbd_pkg::PH_DATA;
                    return 1'b0;
                end
                if (cr_held) begin
                    cr_held = 1'b0;
                    if (!take_size_char(hcbd_pkg::CHAR_CR)) return reject(r);
                end
                if (b == hcbd_pkg::CHAR_CR) begin
                    cr_held = 1'b1;
                    return 1'b0;
                end
                if (!take_size_char(b)) return reject(r);
                return 1'b0;
            end
            hcbd_pkg::PH_DATA: begin
                chunk_left = chunk_left - 1'b1;
                if (chunk_left == 0) phase = hcbd_pkg::PH_DATA_CR;
                r.result_kind = hcbd_pkg::KIND_PAYLOAD;
                r.payload_byte = b;
                return 1'b1;
            end
            hcbd_pkg::PH_DATA_CR: begin
                if (b != hcbd_pkg::CHAR_CR) return reject(r);
                phase = hcbd_pkg::PH_DATA_LF;
                return 1'b0;
            end
            hcbd_pkg::PH_DATA_LF: begin
                if (b != hcbd_pkg::CHAR_LF) return reject(r);
                phase = hcbd_pkg::PH_LEAD;
                return 1'b0;
            end
            hcbd_pkg::PH_END_CR: begin
                if (b != hcbd_pkg::CHAR_CR) return reject(r);
                phase = hcbd_pkg::PH_END_LF;
                return 1'b0;
            end
            hcbd_pkg::PH_END_LF: begin
                if (b != hcbd_pkg::CHAR_LF) return reject(r);
                phase = hcbd_pkg::PH_DONE;
                r.result_kind = hcbd_pkg::KIND_END;
                return 1'b1;
            end
            default: begin
                return 1'b0;
            end
        endcase
    endfunction

    function automatic void note_mismatch(input string what,
                                          input hcbd_pkg::out_word_t exp_w,
                                          input hcbd_pkg::out_word_t got_w);
        if (n_bad < 10) begin
            $display("MISMATCH %s: expected kind %0d byte 0x%02h, got kind %0d byte 0x%02h",
                     what, exp_w.result_kind, exp_w.payload_byte,
                     got_w.result_kind, got_w.payload_byte);
        end
        n_bad++;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            line_limit = hcbd_pkg::MAX_LINE_RESET;
            clear_parser();
            predicted_words.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (predicted_words.size() == 0) begin
                    note_mismatch("word with nothing predicted", '0, m_word);
                end else begin
                    want = predicted_words.pop_front();
                    if (m_word.result_kind !== want.result_kind ||
                        m_word.payload_byte !== want.payload_byte) begin
                        note_mismatch("field difference", want, m_word);
                    end
                end
            end
            if (cfg_wr_en) line_limit = cfg_wr_data;
            if (s_valid && s_ready) begin
                if (decode_byte(s_word, produced)) begin
                    predicted_words = {predicted_words, produced};
                    case (produced.result_kind)
                        hcbd_pkg::KIND_PAYLOAD: n_pay++;
                        hcbd_pkg::KIND_END:     n_end++;
                        default:                n_err++;
                    endcase
                end
            end
        end
        mismatch_count <= n_bad;
        backlog <= predicted_words.size();
        payload_count <= n_pay;
        end_count <= n_end;
        error_count <= n_err;
    end

endmodule

[tb/sv/tb_http_chunked_body_decoder_top.sv]
// Testbench top for the HTTP chunked body decoder: drives chunked bodies, the size line
// limit and output back-pressure, and reports the verdict.
// Depends on hcbd_pkg, http_chunked_body_decoder_top and hcbd_decode_checker.
module tb_http_chunked_body_decoder_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned LONG_HOLD   = 300;
    localparam int unsigned IDLE_LIMIT  = 2500;
    localparam int unsigned PHASE_BYTES = 145;

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    hcbd_pkg::in_word_t  s_word;
    logic                m_valid;
    logic                m_ready;
    hcbd_pkg::out_word_t m_word;
    logic                cfg_wr_en;
    logic [7:0]          cfg_wr_data;

    int unsigned mismatch_count;
    int unsigned backlog;
    int unsigned payload_count;
    int unsigned end_count;
    int unsigned error_count;

    logic [7:0]  body_q[$];
    int          restart_at;
    int unsigned bytes_sent;
    int unsigned bodies_sent;
    bit          long_hold_req;

    http_chunked_body_decoder_top i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_word      (s_word),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_word      (m_word),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    hcbd_decode_checker i_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_word         (s_word),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_word         (m_word),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .mismatch_count (mismatch_count),
        .backlog        (backlog),
        .payload_count  (payload_count),
        .end_count      (end_count),
        .error_count    (error_count)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic void add_byte(input logic [7:0] v);
        body_q = {body_q, v};
    endfunction

    function automatic logic [7:0] hex_char(input int unsigned d);
        if (d < 10) return 8'h30 + 8'(d);
        if ($urandom_range(0, 1) == 1) return 8'h41 + 8'(d - 10);
        return 8'h61 + 8'(d - 10);
    endfunction

    function automatic void push_text(input string t);
        for (int k = 0; k < t.len(); k++) add_byte(t[k]);
    endfunction

    function automatic void push_size_line(input int unsigned size, input bit fancy);
        int unsigned ndig;
        if (fancy) repeat ($urandom_range(0, 2)) add_byte(hcbd_pkg::CHAR_SP);
        if (fancy && $urandom_range(0, 3) == 0) add_byte(8'h30);
        ndig = 1;
        while (ndig < 8 && (size >> (4 * ndig)) != 0) ndig++;
        for (int k = ndig - 1; k >= 0; k--) begin
            add_byte(hex_char((size >> (4 * k)) & 15));
        end
        if (fancy) begin
            case ($urandom_range(0, 5))
                0: push_text(";ext=1");
                1: push_text(" ;x");
                2: begin
                    add_byte(hcbd_pkg::CHAR_CR);
                    add_byte(8'h7A);
                end
                3: begin
                    add_byte(hcbd_pkg::CHAR_LF);
                    add_byte(8'h71);
                end
                default: ;
            endcase
        end
        add_byte(hcbd_pkg::CHAR_CR);
        add_byte(hcbd_pkg::CHAR_LF);
    endfunction

    // Mostly well-formed bodies with random content; up to one in four is damaged in some way.
    function automatic void build_body(input int unsigned lim);
        bit          fancy;
        int unsigned size;
        int unsigned r;
        int unsigned cut;
        logic [7:0]  prefix[$];
        fancy = (lim >= 12) && ($urandom_range(0, 1) == 1);
        body_q.delete();
        restart_at = -1;
        repeat ($urandom_range(0, 3)) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                size = $urandom_range(1, 6);
            end else if (r < 95) begin
                size = $urandom_range(7, 24);
            end else begin
                size = $urandom_range(25, 60);
            end
            push_size_line(size, fancy);
            repeat (size) add_byte(8'($urandom_range(0, 255)));
            add_byte(hcbd_pkg::CHAR_CR);
            add_byte(hcbd_pkg::CHAR_LF);
        end
        if (fancy && $urandom_range(0, 3) == 0) begin
            push_text(" ;last");
            add_byte(hcbd_pkg::CHAR_CR);
            add_byte(hcbd_pkg::CHAR_LF);
        end else begin
            push_size_line(0, fancy);
        end
        add_byte(hcbd_pkg::CHAR_CR);
        add_byte(hcbd_pkg::CHAR_LF);
        if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 3)) add_byte(8'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 3) != 0) return;
        case ($urandom_range(0, 5))
            0: body_q[$urandom_range(0, body_q.size() - 1)] = 8'($urandom_range(0, 255));
            1: begin
                cut = $urandom_range(1, body_q.size());
                body_q = body_q[0:cut-1];
            end
            2: begin
                if ($urandom_range(0, 1) == 1) prefix = {prefix, 8'h30};
                prefix = {prefix, hex_char($urandom_range(1, 15))};
                repeat ($urandom_range(7, 10)) begin
                    prefix = {prefix, hex_char($urandom_range(0, 15))};
                end
                prefix = {prefix, hcbd_pkg::CHAR_CR, hcbd_pkg::CHAR_LF};
                body_q = {prefix, body_q};
            end
            3: begin
                if (lim <= 64) begin
                    repeat (lim + $urandom_range(0, 2)) prefix = {prefix, hcbd_pkg::CHAR_SP};
                    prefix = {prefix, 8'h31, hcbd_pkg::CHAR_CR, hcbd_pkg::CHAR_LF};
                    body_q = {prefix, body_q};
                end
            end
            4: restart_at = $urandom_range(1, body_q.size() - 1);
            default: body_q.insert($urandom_range(0, body_q.size()), 8'($urandom_range(0, 255)));
        endcase
    endfunction

    task automatic send_byte(input logic [7:0] d, input bit ms, input bit no_gap);
        int unsigned g;
        g = no_gap ? 0 : pick_gap();
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_word <= '{data_byte: d, message_start: ms};
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        bytes_sent++;
    endtask

    task automatic send_body(input bit no_gap);
        foreach (body_q[i]) send_byte(body_q[i], (i == 0) || (i == restart_at), no_gap);
        bodies_sent++;
    endtask

    task automatic wait_quiet();
        s_valid <= 1'b0;
        do @(negedge aclk); while (backlog != 0);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_limit(input logic [7:0] v);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        int unsigned hold_left;
        int unsigned run_left;
        hold_left = 0;
        run_left = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold_left = LONG_HOLD - 1;
                m_ready <= 1'b0;
            end else if (run_left > 0) begin
                run_left--;
                m_ready <= 1'b1;
            end else begin
                hold_left = pick_gap();
                run_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                        : $urandom_range(1, 12);
                m_ready <= (hold_left == 0);
                if (hold_left > 0) hold_left--;
            end
        end
    end

    initial begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("Run stopped after %0d idle cycles with %0d input bytes sent.",
                 quiet, bytes_sent);
        $display("end of test: mismatches");
        $finish;
    end

    initial begin
        logic [7:0]  limits[6];
        int unsigned phase_start;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_word = '0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        long_hold_req = 1'b0;
        bytes_sent = 0;
        bodies_sent = 0;
        restart_at = -1;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        body_q = '{hcbd_pkg::CHAR_SP, 8'h31, hcbd_pkg::CHAR_CR, 8'h78, hcbd_pkg::CHAR_LF,
                   hcbd_pkg::CHAR_CR, hcbd_pkg::CHAR_LF, 8'hFF, 8'h51, 8'h00};
        send_body(1'b0);
        body_q = '{hcbd_pkg::CHAR_CR, hcbd_pkg::CHAR_LF, hcbd_pkg::CHAR_CR,
                   hcbd_pkg::CHAR_LF, 8'h80};
        send_body(1'b0);
        body_q = '{8'h66, 8'h46, 8'h61, 8'h41, 8'h39, 8'h30, 8'h65, 8'h45, 8'h64};
        send_body(1'b0);
        wait_quiet();
        write_limit(8'd1);
        body_q = '{8'h35, 8'h35};
        send_body(1'b0);

        limits[0] = 8'd255;
        limits[1] = 8'd1;
        limits[2] = 8'($urandom_range(2, 11));
        limits[3] = 8'($urandom_range(12, 254));
        limits[4] = 8'd2;
        limits[5] = hcbd_pkg::MAX_LINE_RESET;
        for (int p = 0; p < 6; p++) begin
            wait_quiet();
            write_limit(limits[p]);
            if (p == 2) long_hold_req = 1'b1;
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES) begin
                build_body(limits[p]);
                send_body($urandom_range(0, 3) == 0);
            end
        end

        s_valid <= 1'b0;
        do @(negedge aclk); while (backlog != 0);
        repeat (8) @(negedge aclk);

        $display("Covered %0d input bytes in %0d bodies: %0d payload bytes, %0d body ends,",
                 bytes_sent, bodies_sent, payload_count, end_count);
        $display("%0d framing errors, size line limits from 1 to 255, one long output stall.",
                 error_count);
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
